@@ rtl/core/mps_pkg.sv @@
// ----------------------------------------------------------------------------
// mps_pkg
// shared types, codes and constants of the multi-policy job scheduler
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int JOBS_DEF  = 16;
    localparam int ARR_W     = 16;
    localparam int REM_W     = 31;
    localparam int WORD_W    = ARR_W + REM_W;
    localparam logic [REM_W-1:0] REM_UNLIMITED = {REM_W{1'b1}};
    localparam logic [7:0] SLICE_RESET = 8'd2;

    localparam logic [1:0] CMD_RESTART = 2'd0;
    localparam logic [1:0] CMD_LOAD    = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_SLICE  = 2'd1;
    localparam logic [1:0] CFG_JOBCNT = 2'd2;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_SJF  = 2'd1;
    localparam logic [1:0] POL_RR   = 2'd2;
    localparam logic [1:0] POL_SRTF = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ARR,
        S_SEL,
        S_DEC
    } t_state;

    // candidate stream control from the scan pipeline to the picker
    typedef struct packed {
        logic clr;
        logic vld;
        logic live;
    } t_pick_ctl;

endpackage

@@ rtl/core/mps_ram.sv @@
// ----------------------------------------------------------------------------
// mps_ram
// generic one-write one-read synchronous ram with registered read
// ----------------------------------------------------------------------------
module mps_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                     i_wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                     o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/mps_pick.sv @@
// ----------------------------------------------------------------------------
// mps_pick
// tracks candidates of the ready list scan and selects the job to run
// ----------------------------------------------------------------------------
module mps_pick
    import mps_pkg::*;
#(
    parameter int JOBS = JOBS_DEF
) (
    input  logic                                  i_clk,
    input  t_pick_ctl                             i_ctl,
    input  logic [((JOBS > 1) ? $clog2(JOBS) : 1)-1:0] i_pos,
    input  logic [((JOBS > 1) ? $clog2(JOBS) : 1)-1:0] i_job,
    input  logic [WORD_W-1:0]                     i_word,
    input  logic [((JOBS > 1) ? $clog2(JOBS) : 1)-1:0] i_cur,
    input  logic [1:0]                            i_policy,
    input  logic                                  i_hold,
    input  logic                                  i_slice_hit,
    output logic                                  o_found,
    output logic                                  o_cur_live,
    output logic [((JOBS > 1) ? $clog2(JOBS) : 1)-1:0] o_pos,
    output logic [((JOBS > 1) ? $clog2(JOBS) : 1)-1:0] o_job,
    output logic [WORD_W-1:0]                     o_word
);

    localparam int JW = (JOBS > 1) ? $clog2(JOBS) : 1;

    // first live, first live after current, current, shortest
    logic              r_fst_v, r_aft_v, r_cu_v, r_sh_v;
    logic [JW-1:0]     r_fst_p, r_aft_p, r_cu_p, r_sh_p;
    logic [JW-1:0]     r_fst_j, r_aft_j, r_cu_j, r_sh_j;
    logic [WORD_W-1:0] r_fst_w, r_aft_w, r_cu_w, r_sh_w;
    logic              take;

    assign take = i_ctl.vld & i_ctl.live;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr) begin
            r_fst_v <= 1'b0;
            r_aft_v <= 1'b0;
            r_cu_v  <= 1'b0;
            r_sh_v  <= 1'b0;
        end else if (take) begin
            if (!r_fst_v) begin
                r_fst_v <= 1'b1;
                r_fst_p <= i_pos;
                r_fst_j <= i_job;
                r_fst_w <= i_word;
            end
            if (!r_aft_v && (i_pos > i_cur)) begin
                r_aft_v <= 1'b1;
                r_aft_p <= i_pos;
                r_aft_j <= i_job;
                r_aft_w <= i_word;
            end
            if (i_pos == i_cur) begin
                r_cu_v <= 1'b1;
                r_cu_p <= i_pos;
                r_cu_j <= i_job;
                r_cu_w <= i_word;
            end
            // strict compare keeps the earliest position on ties
            if (!r_sh_v || (i_word[REM_W-1:0] < r_sh_w[REM_W-1:0])) begin
                r_sh_v <= 1'b1;
                r_sh_p <= i_pos;
                r_sh_j <= i_job;
                r_sh_w <= i_word;
            end
        end
    end

    assign o_cur_live = r_cu_v;

    always_comb begin
        o_found = r_sh_v;
        o_pos   = r_sh_p;
        o_job   = r_sh_j;
        o_word  = r_sh_w;
        case (i_policy)
            POL_FIFO: begin
                o_found = r_fst_v;
                o_pos   = r_fst_p;
                o_job   = r_fst_j;
                o_word  = r_fst_w;
            end
            POL_SJF: begin
                if (i_hold && r_cu_v) begin
                    o_found = 1'b1;
                    o_pos   = r_cu_p;
                    o_job   = r_cu_j;
                    o_word  = r_cu_w;
                end
            end
            POL_RR: begin
                if (r_cu_v && !i_slice_hit) begin
                    o_found = 1'b1;
                    o_pos   = r_cu_p;
                    o_job   = r_cu_j;
                    o_word  = r_cu_w;
                end else if (r_aft_v) begin
                    o_found = 1'b1;
                    o_pos   = r_aft_p;
                    o_job   = r_aft_j;
                    o_word  = r_aft_w;
                end else begin
                    o_found = r_fst_v;
                    o_pos   = r_fst_p;
                    o_job   = r_fst_j;
                    o_word  = r_fst_w;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/core/multi_policy_job_scheduler_top.sv @@
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler_top
// job table scheduler with fifo, sjf, round robin and srtf policies
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  ----------+----------------------------+----------------------------------
//  command   | start & !busy              | i_command, i_job_index,
//            |                            | i_arrival_tick, i_duration,
//            |                            | i_job_exited
//  result    | o_valid, one cycle strobe  | o_ran_job, o_idle,
//            |                            | o_job_finished, o_hit_limit,
//            |                            | o_all_done, o_tick_now
//  config    | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// restart and load keep busy low and give no word
// a tick holds busy through one job table read per job for arrivals, then a
// two-stage scan of the ready list through the ready ram and the job ram,
// then the update state; the word follows in the next cycle
// a tick after all jobs finished answers without going busy
// reset is synchronous active low and clears control state only
// the receiver cannot stall; the result strobe lasts exactly one cycle
// ----------------------------------------------------------------------------
module multi_policy_job_scheduler_top
    import mps_pkg::*;
#(
    parameter int JOBS = JOBS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_command,
    input  logic [3:0]          i_job_index,
    input  logic [15:0]         i_arrival_tick,
    input  logic signed [16:0]  i_duration,
    input  logic                i_job_exited,
    output logic                o_valid,
    output logic [3:0]          o_ran_job,
    output logic                o_idle,
    output logic                o_job_finished,
    output logic                o_hit_limit,
    output logic                o_all_done,
    output logic [15:0]         o_tick_now,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_data
);

    localparam int JW = (JOBS > 1) ? $clog2(JOBS) : 1;
    localparam int CW = $clog2(JOBS + 1);

    t_state r_state, n_state;

    // configuration
    logic [1:0] r_policy, n_policy;
    logic [7:0] r_slice, n_slice;
    logic [4:0] r_jobcnt, n_jobcnt;

    // per-job status: not arrived when both clear
    logic [JOBS-1:0] r_arr, n_arr;
    logic [JOBS-1:0] r_fin, n_fin;

    // schedule state
    logic [CW-1:0] r_len, n_len;
    logic [JW-1:0] r_cur, n_cur;
    logic [7:0]    r_slc, n_slc;
    logic          r_hold, n_hold;
    logic [4:0]    r_fcnt, n_fcnt;
    logic [15:0]   r_tick, n_tick;

    // scan counters and pipeline
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_p, n_p;
    logic          r_v1, n_v1;
    logic [JW-1:0] r_p1, n_p1;
    logic          r_v2, n_v2;
    logic [JW-1:0] r_p2, n_p2;
    logic [JW-1:0] r_j2, n_j2;
    logic          r_live2, n_live2;
    logic          r_exit, n_exit;

    // result word
    logic        r_ov, n_ov;
    logic [3:0]  r_oran, n_oran;
    logic        r_oidle, n_oidle;
    logic        r_ofin, n_ofin;
    logic        r_olim, n_olim;
    logic        r_oall, n_oall;
    logic [15:0] r_otick, n_otick;

    // memories
    logic              jram_we;
    logic [JW-1:0]     jram_waddr, jram_raddr;
    logic [WORD_W-1:0] jram_wdata, jram_rdata;
    logic              rram_we;
    logic [JW-1:0]     rram_waddr, rram_raddr;
    logic [JW-1:0]     rram_wdata, rram_rdata;

    // picker
    t_pick_ctl         pctl;
    logic              pk_found, pk_cur_live;
    logic [JW-1:0]     pk_pos, pk_job;
    logic [WORD_W-1:0] pk_word;

    logic [CW-1:0]    n_lim;
    logic             fcnt_ge_n;
    logic [7:0]       slice_eff;
    logic             slice_hit;
    logic             slice_clr;
    logic [JW-1:0]    ldx;
    logic [REM_W-1:0] rem_ld;
    logic [JW-1:0]    ci;
    logic [CW-1:0]    cnt1;
    logic [REM_W-1:0] rem_d;
    logic             done;
    logic [4:0]       fcnt_nx;

    mps_ram #(.W(WORD_W), .D(JOBS)) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (jram_we),
        .i_waddr (jram_waddr),
        .i_wdata (jram_wdata),
        .i_raddr (jram_raddr),
        .o_rdata (jram_rdata)
    );

    mps_ram #(.W(JW), .D(JOBS)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (rram_we),
        .i_waddr (rram_waddr),
        .i_wdata (rram_wdata),
        .i_raddr (rram_raddr),
        .o_rdata (rram_rdata)
    );

    mps_pick #(.JOBS(JOBS)) u_pick (
        .i_clk       (i_clk),
        .i_ctl       (pctl),
        .i_pos       (r_p2),
        .i_job       (r_j2),
        .i_word      (jram_rdata),
        .i_cur       (r_cur),
        .i_policy    (r_policy),
        .i_hold      (r_hold),
        .i_slice_hit (slice_hit),
        .o_found     (pk_found),
        .o_cur_live  (pk_cur_live),
        .o_pos       (pk_pos),
        .o_job       (pk_job),
        .o_word      (pk_word)
    );

    // effective job count, capped at the table depth
    assign n_lim     = (32'(r_jobcnt) < JOBS) ? CW'(r_jobcnt) : CW'(JOBS);
    assign fcnt_ge_n = 32'(r_fcnt) >= 32'(n_lim);

    // zero slice acts as one tick
    assign slice_eff = (r_slice == 8'd0) ? 8'd1 : r_slice;
    assign slice_hit = r_slc >= slice_eff;
    assign slice_clr = (r_policy == POL_RR) && pk_cur_live && slice_hit;

    assign ldx    = JW'(32'(i_job_index));
    // any negative duration means unlimited
    assign rem_ld = i_duration[16] ? REM_UNLIMITED : REM_W'(i_duration[15:0]);
    assign ci     = r_cnt[JW-1:0];
    assign cnt1   = r_cnt + CW'(1);

    // remaining time saturates at zero
    assign rem_d   = (pk_word[REM_W-1:0] != '0) ? pk_word[REM_W-1:0] - REM_W'(1) : '0;
    assign done    = r_exit || (rem_d == '0);
    assign fcnt_nx = (done && (r_fcnt != 5'd31)) ? r_fcnt + 5'd1 : r_fcnt;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_policy = r_policy;
        n_slice  = r_slice;
        n_jobcnt = r_jobcnt;
        n_arr    = r_arr;
        n_fin    = r_fin;
        n_len    = r_len;
        n_cur    = r_cur;
        n_slc    = r_slc;
        n_hold   = r_hold;
        n_fcnt   = r_fcnt;
        n_tick   = r_tick;
        n_cnt    = r_cnt;
        n_p      = r_p;
        n_v1     = 1'b0;
        n_p1     = r_p1;
        n_v2     = 1'b0;
        n_p2     = r_p2;
        n_j2     = r_j2;
        n_live2  = r_live2;
        n_exit   = r_exit;
        n_ov     = 1'b0;
        n_oran   = r_oran;
        n_oidle  = r_oidle;
        n_ofin   = r_ofin;
        n_olim   = r_olim;
        n_oall   = r_oall;
        n_otick  = r_otick;

        jram_we    = 1'b0;
        jram_waddr = ldx;
        jram_wdata = {i_arrival_tick, rem_ld};
        jram_raddr = '0;
        rram_we    = 1'b0;
        rram_waddr = r_len[JW-1:0];
        rram_wdata = ci;
        rram_raddr = r_p[JW-1:0];
        pctl       = '0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLICY: n_policy = i_cfg_data[1:0];
                CFG_SLICE:  n_slice  = i_cfg_data;
                CFG_JOBCNT: n_jobcnt = i_cfg_data[4:0];
                default: begin
                end
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_command)
                        CMD_RESTART: begin
                            n_arr  = '0;
                            n_fin  = '0;
                            n_len  = '0;
                            n_cur  = '0;
                            n_slc  = '0;
                            n_hold = 1'b0;
                            n_fcnt = '0;
                            n_tick = '0;
                        end
                        CMD_LOAD: begin
                            if (32'(i_job_index) < JOBS) begin
                                jram_we    = 1'b1;
                                n_arr[ldx] = 1'b0;
                                n_fin[ldx] = 1'b0;
                            end
                        end
                        CMD_TICK: begin
                            n_otick = r_tick;
                            n_oran  = '0;
                            n_ofin  = 1'b0;
                            n_olim  = 1'b0;
                            if (fcnt_ge_n) begin
                                // everything finished: answer at once
                                n_ov    = 1'b1;
                                n_oidle = 1'b1;
                                n_oall  = 1'b1;
                            end else begin
                                // job ram address zero is read this cycle
                                n_state = S_ARR;
                                n_cnt   = '0;
                                n_exit  = i_job_exited;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ARR: begin
                jram_raddr = cnt1[JW-1:0];
                if ((jram_rdata[WORD_W-1:REM_W] == r_tick) && !r_arr[ci] && !r_fin[ci]) begin
                    n_arr[ci] = 1'b1;
                    if (32'(r_len) < JOBS) begin
                        rram_we = 1'b1;
                        n_len   = r_len + CW'(1);
                    end
                end
                if (cnt1 < n_lim) begin
                    n_cnt = cnt1;
                end else begin
                    n_state  = S_SEL;
                    n_p      = '0;
                    pctl.clr = 1'b1;
                end
            end

            S_SEL: begin
                // stage 0: ready list read
                if (r_p < r_len) begin
                    n_v1 = 1'b1;
                    n_p1 = r_p[JW-1:0];
                    n_p  = r_p + CW'(1);
                end
                // stage 1: job table read of the listed job
                jram_raddr = rram_rdata;
                n_v2       = r_v1;
                n_p2       = r_p1;
                n_j2       = rram_rdata;
                n_live2    = !r_fin[rram_rdata];
                // stage 2: candidate into the picker
                pctl.vld   = r_v2;
                pctl.live  = r_live2;
                if (!(r_p < r_len) && !r_v1 && !r_v2) begin
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_state = S_IDLE;
                n_ov    = 1'b1;
                if (r_tick != 16'hFFFF) begin
                    n_tick = r_tick + 16'd1;
                end
                if (slice_clr) begin
                    n_slc = '0;
                end
                if (!pk_found) begin
                    n_oidle = 1'b1;
                    n_oall  = 1'b0;
                end else begin
                    jram_we       = 1'b1;
                    jram_waddr    = pk_job;
                    jram_wdata    = {pk_word[WORD_W-1:REM_W], rem_d};
                    n_arr[pk_job] = 1'b1;
                    n_fin[pk_job] = done;
                    n_fcnt        = fcnt_nx;
                    n_cur         = pk_pos;
                    if (r_policy == POL_RR) begin
                        if (done) begin
                            n_slc = '0;
                        end else if (slice_clr) begin
                            n_slc = 8'd1;
                        end else if (r_slc != 8'hFF) begin
                            n_slc = r_slc + 8'd1;
                        end
                    end
                    n_hold  = (r_policy == POL_SJF) && !done;
                    n_oran  = 4'(pk_job);
                    n_oidle = 1'b0;
                    n_ofin  = done;
                    n_olim  = !r_exit && (rem_d == '0);
                    n_oall  = 32'(fcnt_nx) >= 32'(n_lim);
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_policy <= POL_FIFO;
            r_slice  <= SLICE_RESET;
            r_jobcnt <= '0;
            r_arr    <= '0;
            r_fin    <= '0;
            r_len    <= '0;
            r_cur    <= '0;
            r_slc    <= '0;
            r_hold   <= 1'b0;
            r_fcnt   <= '0;
            r_tick   <= '0;
            r_cnt    <= '0;
            r_p      <= '0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_policy <= n_policy;
            r_slice  <= n_slice;
            r_jobcnt <= n_jobcnt;
            r_arr    <= n_arr;
            r_fin    <= n_fin;
            r_len    <= n_len;
            r_cur    <= n_cur;
            r_slc    <= n_slc;
            r_hold   <= n_hold;
            r_fcnt   <= n_fcnt;
            r_tick   <= n_tick;
            r_cnt    <= n_cnt;
            r_p      <= n_p;
            r_v1     <= n_v1;
            r_v2     <= n_v2;
            r_ov     <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p1    <= n_p1;
        r_p2    <= n_p2;
        r_j2    <= n_j2;
        r_live2 <= n_live2;
        r_exit  <= n_exit;
        r_oran  <= n_oran;
        r_oidle <= n_oidle;
        r_ofin  <= n_ofin;
        r_olim  <= n_olim;
        r_oall  <= n_oall;
        r_otick <= n_otick;
    end

    assign o_valid        = r_ov;
    assign o_ran_job      = r_oran;
    assign o_idle         = r_oidle;
    assign o_job_finished = r_ofin;
    assign o_hit_limit    = r_olim;
    assign o_all_done     = r_oall;
    assign o_tick_now     = r_otick;

    // ready list never grows past the table depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= JOBS)
        else $error("ready list length beyond table depth");

    // a result word is only shown once the sequencer is back at rest
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while busy");

    // a run that completes the schedule must have finished its job
    a_all_done_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_all_done && !o_idle) |-> o_job_finished)
        else $error("all done without a finishing job");

    // the scan pipeline drains before the update cycle
    a_scan_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DEC) |-> (!r_v1 && !r_v2))
        else $error("update with scan still in flight");

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the multi-policy job scheduler: directed schedules,
// then random job sets ticked until all done or a tick limit, under all four policies
// ----------------------------------------------------------------------------
module testbench;
    import mps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NJOB = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;

    // one queued command word
    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         job_index;
        logic [15:0]        arrival_tick;
        logic signed [16:0] duration;
        logic               job_exited;
    } t_cmd_word;

    // one scheduled-tick result
    typedef struct packed {
        logic [3:0]  ran_job;
        logic        idle;
        logic        job_finished;
        logic        hit_limit;
        logic        all_done;
        logic [15:0] tick_now;
    } t_tick_word;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_command;
    logic [3:0]         i_job_index;
    logic [15:0]        i_arrival_tick;
    logic signed [16:0] i_duration;
    logic               i_job_exited;
    logic               o_valid;
    logic [3:0]         o_ran_job;
    logic               o_idle;
    logic               o_job_finished;
    logic               o_hit_limit;
    logic               o_all_done;
    logic [15:0]        o_tick_now;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [7:0]         i_cfg_data;

    multi_policy_job_scheduler_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_job_index    (i_job_index),
        .i_arrival_tick (i_arrival_tick),
        .i_duration     (i_duration),
        .i_job_exited   (i_job_exited),
        .o_valid        (o_valid),
        .o_ran_job      (o_ran_job),
        .o_idle         (o_idle),
        .o_job_finished (o_job_finished),
        .o_hit_limit    (o_hit_limit),
        .o_all_done     (o_all_done),
        .o_tick_now     (o_tick_now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // scheduler shadow state, updated as each command is queued
    // ------------------------------------------------------------------------
    logic [1:0]  sh_policy;
    logic [7:0]  sh_slice;
    logic [4:0]  sh_job_count;
    logic [15:0] sh_arrival [NJOB];
    logic [31:0] sh_remaining [NJOB];
    logic [1:0]  sh_status [NJOB];
    logic [3:0]  sh_ready [NJOB];
    int unsigned sh_ready_len;
    int unsigned sh_cur_pos;
    int unsigned sh_slice_cnt;
    bit          sh_holding;
    int unsigned sh_finished;
    int unsigned sh_tick;

    localparam logic [1:0] ST_NOT_ARRIVED = 2'd0;
    localparam logic [1:0] ST_ARRIVED     = 2'd1;
    localparam logic [1:0] ST_FINISHED    = 2'd3;
    localparam logic [1:0] CMD_UNUSED     = 2'd3;

    t_cmd_word  pending_words [$];
    t_tick_word expected_ticks [$];

    int unsigned mismatch_count;
    int unsigned checked_count;
    int unsigned issued_ticks;

    function automatic bit position_live(int unsigned p);
        if (p >= sh_ready_len || p >= NJOB) return 1'b0;
        return sh_status[sh_ready[p]] != ST_FINISHED;
    endfunction

    function automatic bit shortest_position(output int unsigned pos);
        bit found;
        int unsigned best;
        found = 1'b0;
        best = 0;
        for (int unsigned p = 0; p < sh_ready_len; p++) begin
            if (position_live(p) &&
                (!found || sh_remaining[sh_ready[p]] < sh_remaining[sh_ready[best]])) begin
                best = p;
                found = 1'b1;
            end
        end
        pos = best;
        return found;
    endfunction

    function automatic bit next_cyclic_position(int unsigned from, output int unsigned pos);
        int unsigned p;
        pos = 0;
        if (sh_ready_len == 0) return 1'b0;
        for (int unsigned k = 1; k <= sh_ready_len; k++) begin
            p = (from % sh_ready_len + k) % sh_ready_len;
            if (position_live(p)) begin
                pos = p;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void restart_shadow();
        for (int i = 0; i < NJOB; i++) begin
            sh_status[i] = ST_NOT_ARRIVED;
            sh_ready[i] = '0;
        end
        sh_ready_len = 0;
        sh_cur_pos = 0;
        sh_slice_cnt = 0;
        sh_holding = 1'b0;
        sh_finished = 0;
        sh_tick = 0;
    endfunction

    // advance the shadow by one command; returns 1 and the word on a tick
    function automatic bit schedule_step(t_cmd_word w, output t_tick_word r);
        int unsigned n, pos, job, slice;
        bit found, done, limit;
        r = '0;
        pos = 0;
        found = 1'b0;
        done = 1'b0;
        limit = 1'b0;
        case (w.command)
            CMD_RESTART: begin
                restart_shadow();
                return 1'b0;
            end
            CMD_LOAD: begin
                sh_arrival[w.job_index] = w.arrival_tick;
                sh_remaining[w.job_index] = w.duration[16] ? 32'd2147483647
                                                           : {15'd0, w.duration};
                sh_status[w.job_index] = ST_NOT_ARRIVED;
                return 1'b0;
            end
            CMD_TICK: ;
            default: return 1'b0;
        endcase
        n = (sh_job_count < NJOB) ? sh_job_count : NJOB;
        r.tick_now = sh_tick[15:0];
        if (sh_finished >= n) begin
            r.idle = 1'b1;
            r.all_done = 1'b1;
            return 1'b1;
        end
        for (int unsigned i = 0; i < n; i++) begin
            if (sh_arrival[i] == sh_tick && sh_status[i] == ST_NOT_ARRIVED) begin
                sh_status[i] = ST_ARRIVED;
                if (sh_ready_len < NJOB) begin
                    sh_ready[sh_ready_len] = i[3:0];
                    sh_ready_len++;
                end
            end
        end
        case (sh_policy)
            POL_FIFO: begin
                for (int unsigned i = 0; i < sh_ready_len; i++) begin
                    if (!found && position_live(i)) begin
                        pos = i;
                        found = 1'b1;
                    end
                end
            end
            POL_SJF: begin
                if (sh_holding && position_live(sh_cur_pos)) begin
                    pos = sh_cur_pos;
                    found = 1'b1;
                end else begin
                    found = shortest_position(pos);
                end
            end
            POL_RR: begin
                slice = (sh_slice != 0) ? sh_slice : 1;
                if (!position_live(sh_cur_pos)) begin
                    found = next_cyclic_position(sh_cur_pos, pos);
                end else if (sh_slice_cnt >= slice) begin
                    sh_slice_cnt = 0;
                    found = next_cyclic_position(sh_cur_pos, pos);
                end else begin
                    pos = sh_cur_pos;
                    found = 1'b1;
                end
            end
            default: found = shortest_position(pos);
        endcase
        if (!found) begin
            r.idle = 1'b1;
            if (sh_tick < 65535) sh_tick++;
            return 1'b1;
        end
        job = sh_ready[pos % NJOB];
        sh_cur_pos = pos;
        if (sh_remaining[job] > 0) sh_remaining[job]--;
        if (w.job_exited) begin
            done = 1'b1;
        end else if (sh_remaining[job] == 0) begin
            done = 1'b1;
            limit = 1'b1;
        end
        if (done) begin
            sh_status[job] = ST_FINISHED;
            if (sh_finished < 31) sh_finished++;
        end else begin
            sh_status[job] = ST_ARRIVED;
        end
        if (sh_policy == POL_RR) begin
            if (done) sh_slice_cnt = 0;
            else if (sh_slice_cnt < 255) sh_slice_cnt++;
        end
        sh_holding = (sh_policy == POL_SJF) && !done;
        if (sh_tick < 65535) sh_tick++;
        r.ran_job = job[3:0];
        r.job_finished = done;
        r.hit_limit = limit;
        r.all_done = sh_finished >= n;
        return 1'b1;
    endfunction

    // queue a command and predict its word
    task automatic push_word(input t_cmd_word w);
        t_tick_word r;
        pending_words = {pending_words, w};
        if (schedule_step(w, r)) begin
            expected_ticks = {expected_ticks, r};
            issued_ticks++;
        end
    endtask

    task automatic push_cmd(input logic [1:0] c, input logic [3:0] idx, input logic [15:0] arr,
                            input logic signed [16:0] dur, input logic ex);
        t_cmd_word w;
        w.command = c;
        w.job_index = idx;
        w.arrival_tick = arr;
        w.duration = dur;
        w.job_exited = ex;
        push_word(w);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch %0s: got %0d expected %0d (word %0d)", what, got, want,
                 checked_count);
    endtask

    // ------------------------------------------------------------------------
    // driver: bursts of words with random gaps
    // ------------------------------------------------------------------------
    int  burst_left;
    int  gap_left;
    bit  hold_off;
    t_cmd_word drive_word;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (start && busy) begin
            // word waiting for acceptance, keep it up
        end else begin
            if (hold_off || pending_words.size() == 0) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else begin
                drive_word = pending_words.pop_front();
                start <= 1'b1;
                i_command <= drive_word.command;
                i_job_index <= drive_word.job_index;
                i_arrival_tick <= drive_word.arrival_tick;
                i_duration <= drive_word.duration;
                i_job_exited <= drive_word.job_exited;
                if (burst_left <= 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end
        end
    end

    // count accepted command words
    int unsigned accepted_words;
    int unsigned idle_cycles;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accepted_words <= 0;
        end else if (start && !busy) begin
            accepted_words <= accepted_words + 1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: check each result word against the oldest prediction
    // ------------------------------------------------------------------------
    t_tick_word want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_ticks.size() == 0) begin
                report_mismatch("unexpected word", 1, 0);
            end else begin
                want = expected_ticks.pop_front();
                if (o_ran_job !== want.ran_job)
                    report_mismatch("ran_job", o_ran_job, want.ran_job);
                if (o_idle !== want.idle)
                    report_mismatch("idle", o_idle, want.idle);
                if (o_job_finished !== want.job_finished)
                    report_mismatch("job_finished", o_job_finished, want.job_finished);
                if (o_hit_limit !== want.hit_limit)
                    report_mismatch("hit_limit", o_hit_limit, want.hit_limit);
                if (o_all_done !== want.all_done)
                    report_mismatch("all_done", o_all_done, want.all_done);
                if (o_tick_now !== want.tick_now)
                    report_mismatch("tick_now", o_tick_now, want.tick_now);
            end
            checked_count <= checked_count + 1;
        end
    end

    // watchdog on cycles with no progress at either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    int unsigned queued_count;

    // wait until every queued word is accepted and every word has come back
    task automatic wait_drained();
        while (pending_words.size() != 0 || start || expected_ticks.size() != 0)
            @(posedge i_clk);
        // a tick may still be in flight after its word leaves the queue
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_POLICY: sh_policy = data[1:0];
            CFG_SLICE:  sh_slice = data;
            default:    sh_job_count = data[4:0];
        endcase
    endtask

    // random duration: mostly short, sometimes unlimited or wide
    function automatic logic signed [16:0] rand_duration();
        case ($urandom_range(0, 9))
            0: return -17'sd1;
            1: return 17'($urandom_range(65536, 131071)); // any negative value
            2: return 17'($urandom_range(0, 65535));
            3: return 17'sd0;
            default: return 17'($urandom_range(1, 6));
        endcase
    endfunction

    // one job set: restart, load jobs 0..n-1, tick until all done or 60 ticks
    task automatic run_job_set(input int unsigned n, input int unsigned span);
        int unsigned guard;
        t_tick_word last;
        logic signed [16:0] d;
        push_cmd(CMD_RESTART, 4'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
        for (int unsigned j = 0; j < n; j++) begin
            d = rand_duration();
            push_cmd(CMD_LOAD, j[3:0], 16'($urandom_range(0, span)), d, 1'($urandom));
        end
        // a sprinkle of noise commands
        if ($urandom_range(0, 3) == 0)
            push_cmd(CMD_UNUSED, 4'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
        guard = 0;
        do begin
            push_cmd(CMD_TICK, 4'($urandom), 16'($urandom), 17'($urandom),
                     ($urandom_range(0, 5) == 0));
            last = expected_ticks[$];
            guard++;
        end while (!last.all_done && guard < 60);
        // bounded length: exit stops unlimited jobs eventually anyway
        queued_count += n + guard + 1;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    int unsigned set_size;

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_command = CMD_RESTART;
        i_job_index = '0;
        i_arrival_tick = '0;
        i_duration = '0;
        i_job_exited = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_POLICY;
        i_cfg_data = '0;
        hold_off = 1'b0;
        mismatch_count = 0;
        checked_count = 0;
        issued_ticks = 0;
        queued_count = 0;
        sh_policy = POL_FIFO;
        sh_slice = SLICE_RESET;
        sh_job_count = '0;
        for (int i = 0; i < NJOB; i++) begin
            sh_arrival[i] = '0;
            sh_remaining[i] = '0;
        end
        restart_shadow();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty job count gives all done on a tick
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b0);
        push_cmd(CMD_UNUSED, 4'hf, 16'hffff, -17'sd1, 1'b1);
        wait_drained();

        // directed: all 16 jobs with extreme fields, fifo, fifteen of them ready at once
        write_reg(CFG_JOBCNT, 8'd16);
        for (int j = 0; j < NJOB; j++)
            push_cmd(CMD_LOAD, 4'(j), (j == 15) ? 16'hffff : 16'd0,
                     (j == 0) ? 17'sd0 : (j == 1) ? 17'sd65535 :
                     (j == 2) ? -17'sd1 : 17'sd1, 1'b0);
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b0);  // zero duration hits limit
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b1);  // exit wins
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b1);
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b0);
        push_cmd(CMD_RESTART, 4'd0, 16'd0, 17'sd0, 1'b0);
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b0);  // jobs arrive again from the kept job table
        wait_drained();

        // directed: round robin with slice 0 and 255, then sjf and srtf short sets
        write_reg(CFG_POLICY, 8'(POL_RR));
        write_reg(CFG_SLICE, 8'd0);
        write_reg(CFG_JOBCNT, 8'd3);
        run_job_set(3, 2);
        wait_drained();
        write_reg(CFG_SLICE, 8'd255);
        run_job_set(3, 2);
        wait_drained();
        write_reg(CFG_POLICY, 8'(POL_SJF));
        run_job_set(3, 3);
        wait_drained();
        write_reg(CFG_POLICY, 8'(POL_SRTF));
        run_job_set(3, 3);
        wait_drained();

        // pause the sender once with a word queued, then release it
        hold_off = 1'b1;
        push_cmd(CMD_TICK, 4'd0, 16'd0, 17'sd0, 1'b0);
        repeat (40) @(posedge i_clk);
        hold_off = 1'b0;
        wait_drained();

        // random job sets across policies, slices and counts
        while (queued_count < 1150) begin
            write_reg(CFG_POLICY, 8'($urandom_range(0, 3)));
            write_reg(CFG_SLICE, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 3)));
            set_size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(1, 6);
            // counts above 16 act as 16; only do that with all jobs loaded
            write_reg(CFG_JOBCNT, (set_size == 16 && $urandom_range(0, 1))
                                  ? 8'($urandom_range(17, 31)) : 8'(set_size));
            run_job_set(set_size, ($urandom_range(0, 3) == 0) ? 12 : 4);
            // occasionally a second set without waiting, so bursts span sets
            if ($urandom_range(0, 2) == 0) run_job_set(set_size, 4);
            wait_drained();
        end

        $display("covered %0d commands, %0d of %0d tick words checked", accepted_words,
                 checked_count, issued_ticks);
        $display("all four policies, slice extremes and job counts 0 to 31 exercised");
        if (mismatch_count == 0 && expected_ticks.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
